>>> hw/rtl/pipeline_hazard_and_branch_profiler_macros.svh
// ---------------------------------------------------------------------------
// Profiler assertion macros
// Shorthand for the concurrent checks of the hazard and branch profiler.
// Each macro expects clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef PIPELINE_HAZARD_AND_BRANCH_PROFILER_MACROS_SVH
`define PIPELINE_HAZARD_AND_BRANCH_PROFILER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PHBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("profiler check failed");

// Next-cycle implication, checked outside reset.
`define PHBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("profiler check failed");

`endif

>>> hw/rtl/phbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Profiler package
// Shared types, opcode and function codes, and sizing constants.
// ---------------------------------------------------------------------------
package phbp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned HISTORY_BITS        = 2;
  localparam int unsigned PATTERN_ENTRIES     = 1 << HISTORY_BITS;
  localparam int unsigned NUM_REGS            = 32;
  localparam int unsigned REG_W               = 5;
  localparam int unsigned CNT_W               = 32;
  localparam int unsigned WINDOW_W            = 4;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 4'd2;
  localparam logic [1:0]          CTR_WEAK_TAKEN = 2'd2;
  localparam logic [1:0]          CTR_MAX        = 2'd3;
  localparam logic [1:0]          CTR_MIN        = 2'd0;

  typedef enum logic [1:0] {
    CLASS_R = 2'd0,
    CLASS_I = 2'd1,
    CLASS_J = 2'd2,
    CLASS_X = 2'd3
  } instr_class_t;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWC1    = 6'h39;

  // Function codes of register-type instructions
  localparam logic [5:0] FN_NONE    = 6'h00;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;

  typedef struct packed {
    instr_class_t       instr_class;
    logic [5:0]         opcode;
    logic [5:0]         func;
    logic [REG_W-1:0]   src_reg;
    logic [REG_W-1:0]   second_reg;
    logic [REG_W-1:0]   dest_reg;
    logic               branch_taken;
    logic signed [15:0] branch_offset;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] instructions_seen;
    logic [CNT_W-1:0] hazards_seen;
    logic [CNT_W-1:0] branches_seen;
    logic [CNT_W-1:0] static_misses;
    logic [CNT_W-1:0] bimodal_misses;
    logic [CNT_W-1:0] two_level_misses;
  } out_item_t;

  // Classified instruction handed from the front to the back.
  typedef struct packed {
    logic hazard;
    logic branch;
    logic taken;
    logic backward;
  } prof_op_t;

endpackage

>>> hw/rtl/phbp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module phbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read in the same cycle as a write to that address returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/phbp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Profiler front end
// Accepts instructions, tracks last writers and flags data hazards.
// ---------------------------------------------------------------------------
module phbp_front import phbp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  in_item_t                           item,
  input  logic [WINDOW_W-1:0]                hazard_window,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level,
  output logic                               push,
  output prof_op_t                           push_op
);

  localparam int unsigned LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  logic              accept;
  logic [LEVEL_W:0]  pending;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [NUM_REGS-1:0] written;

  logic             rtype;
  logic             itype;
  logic [5:0]       fn_eff;
  logic             is_br;
  logic             rd_a;
  logic             rd_b;
  logic             nowrite;
  logic             hilo;
  logic             wr_en;
  logic [REG_W-1:0] wr_addr;

  logic             p1_valid;
  logic [CNT_W-1:0] p1_count;
  logic             p1_rd_a;
  logic             p1_rd_b;
  logic             p1_va;
  logic             p1_vb;
  logic             p1_branch;
  logic             p1_taken;
  logic             p1_backward;

  logic [CNT_W-1:0] rdata_a;
  logic [CNT_W-1:0] rdata_b;
  logic [CNT_W-1:0] dist_a;
  logic [CNT_W-1:0] dist_b;
  logic             hz_a;
  logic             hz_b;

  // Count the word in the pipe register as already queued.
  assign pending    = {1'b0, q_level} + {{LEVEL_W{1'b0}}, p1_valid};
  assign item_ready = !rst && (pending < (LEVEL_W + 1)'(QUEUE_DEPTH));
  assign accept     = item_valid && item_ready;
  assign count_next = count + 1'b1;

  always_comb begin
    rtype  = (item.instr_class == CLASS_R);
    itype  = (item.instr_class == CLASS_I);
    fn_eff = rtype ? item.func : FN_NONE;
    is_br  = (item.opcode == OP_REGIMM) || (item.opcode == OP_BEQ) ||
             (item.opcode == OP_BNE) || (item.opcode == OP_BLEZ) ||
             (item.opcode == OP_BGTZ);
    rd_a = 1'b0;
    rd_b = 1'b0;
    if (rtype) begin
      rd_a = (item.src_reg != '0);
      rd_b = (item.second_reg != '0);
    end else if (itype) begin
      if (item.opcode == OP_LUI) begin
        rd_a = 1'b0;
      end else if (((item.opcode == OP_BEQ) || (item.opcode == OP_BNE)) &&
                   ((item.src_reg != '0) || (item.second_reg != '0))) begin
        // Equality branches read both operands, register zero included.
        rd_a = 1'b1;
        rd_b = 1'b1;
      end else begin
        rd_a = (item.src_reg != '0);
      end
    end
    nowrite = !(rtype || itype);
    if ((item.opcode == OP_SPECIAL) &&
        ((fn_eff == FN_JR) || (fn_eff == FN_SYSCALL) || (fn_eff == FN_BREAK))) begin
      nowrite = 1'b1;
    end
    if ((fn_eff == FN_NONE) && (is_br || (item.opcode == OP_SB) ||
        (item.opcode == OP_SH) || (item.opcode == OP_SW) ||
        (item.opcode == OP_SWC1))) begin
      nowrite = 1'b1;
    end
    // Writes to hi and lo are never read back by a source operand,
    // so they leave the general register table alone.
    hilo = (fn_eff == FN_MULT) || (fn_eff == FN_MULTU) || (fn_eff == FN_DIV) ||
           (fn_eff == FN_DIVU) || (fn_eff == FN_MTHI) || (fn_eff == FN_MTLO);
    wr_en   = accept && !nowrite && !hilo;
    wr_addr = rtype ? item.dest_reg : item.second_reg;
  end

  // Two copies of the last-writer table, one per source operand.
  phbp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_REGS)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (count_next),
    .raddr (item.src_reg),
    .rdata (rdata_a)
  );

  phbp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_REGS)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (count_next),
    .raddr (item.second_reg),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      written  <= '0;
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
      if (accept) begin
        count <= count_next;
      end
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_count    <= count_next;
      p1_rd_a     <= rd_a;
      p1_rd_b     <= rd_b;
      p1_va       <= written[item.src_reg];
      p1_vb       <= written[item.second_reg];
      p1_branch   <= itype && is_br;
      p1_taken    <= item.branch_taken;
      p1_backward <= item.branch_offset[15];
    end
  end

  // A register never written reads as index zero.
  assign dist_a = p1_count - (p1_va ? rdata_a : '0);
  assign dist_b = p1_count - (p1_vb ? rdata_b : '0);
  assign hz_a   = p1_rd_a && (dist_a <= CNT_W'(hazard_window));
  assign hz_b   = p1_rd_b && (dist_b <= CNT_W'(hazard_window));

  assign push             = p1_valid;
  assign push_op.hazard   = hz_a || hz_b;
  assign push_op.branch   = p1_branch;
  assign push_op.taken    = p1_taken;
  assign push_op.backward = p1_backward;

endmodule

>>> hw/rtl/phbp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Profiler queue
// Short first-in first-out buffer between the front and the back end.
// ---------------------------------------------------------------------------
module phbp_queue import phbp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  prof_op_t                     push_op,
  input  logic                         pop,
  output logic                         head_valid,
  output prof_op_t                     head_op,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LEVEL_W = $clog2(DEPTH + 1);

  prof_op_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr_next;
  logic [LEVEL_W-1:0] level_next;

  assign wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    level_next = level;
    if (push && !pop) begin
      level_next = level + 1'b1;
    end else if (pop && !push) begin
      level_next = level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  assign head_valid = (level != '0);
  assign head_op    = slots[rd_ptr];

endmodule

>>> hw/rtl/phbp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Profiler back end
// Scores the three branch predictors and keeps the running totals.
// ---------------------------------------------------------------------------
module phbp_back import phbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  prof_op_t  head_op,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  out_item_t               totals_next;
  logic [1:0]              bimodal;
  logic [1:0]              bimodal_next;
  logic [HISTORY_BITS-1:0] history;
  logic [HISTORY_BITS-1:0] history_next;
  logic [HISTORY_BITS:0]   hist_shift;
  logic [1:0]              pattern [PATTERN_ENTRIES];
  logic [1:0]              pattern_sel;
  logic [1:0]              pattern_next;

  function automatic logic [1:0] ctr_step(input logic [1:0] c, input logic taken);
    logic [1:0] r;
    if (taken) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 1'b1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 1'b1;
    end
    return r;
  endfunction

  // The totals register doubles as the result register.
  assign pop = head_valid && (!result_valid || result_ready);

  assign pattern_sel  = pattern[history];
  assign bimodal_next = ctr_step(bimodal, head_op.taken);
  assign pattern_next = ctr_step(pattern_sel, head_op.taken);
  assign hist_shift   = {history, head_op.taken};
  assign history_next = hist_shift[HISTORY_BITS-1:0];

  always_comb begin
    totals_next = result;
    totals_next.instructions_seen = result.instructions_seen + 1'b1;
    if (head_op.hazard) begin
      totals_next.hazards_seen = result.hazards_seen + 1'b1;
    end
    if (head_op.branch) begin
      totals_next.branches_seen = result.branches_seen + 1'b1;
      if (head_op.taken != head_op.backward) begin
        totals_next.static_misses = result.static_misses + 1'b1;
      end
      if (head_op.taken != bimodal[1]) begin
        totals_next.bimodal_misses = result.bimodal_misses + 1'b1;
      end
      if (head_op.taken != pattern_sel[1]) begin
        totals_next.two_level_misses = result.two_level_misses + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result       <= '0;
      result_valid <= 1'b0;
      bimodal      <= CTR_WEAK_TAKEN;
      history      <= '0;
      for (int i = 0; i < PATTERN_ENTRIES; i++) begin
        pattern[i] <= CTR_WEAK_TAKEN;
      end
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
        result       <= totals_next;
        if (head_op.branch) begin
          bimodal          <= bimodal_next;
          pattern[history] <= pattern_next;
          history          <= history_next;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/pipeline_hazard_and_branch_profiler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipeline hazard and branch profiler
// Counts retired instructions, data hazards and branch mispredictions.
// ---------------------------------------------------------------------------
// Usage. Retired instructions arrive as words on the item channel
// (item_valid / item_ready); for every word one result word of six running
// totals leaves on the result channel (result_valid / result_ready). The
// totals are the values after that instruction and wrap modulo 2^32.
// The hazard window is written through cfg_we / cfg_wdata while the block
// is idle; it takes effect for every later instruction.
// Throughput is one instruction per clock while the result channel does
// not stall. The last-writer table is read and the pipe register loaded
// at the accepting edge; the hazard compare then loads the queue, and the
// scoring stage loads the totals register, which drives result_valid.
// The front end and back end are parted by a queue of QUEUE_DEPTH words.
// When the receiver stalls, the totals register holds its word, the queue
// fills, and item_ready falls once the queue and the pipe register
// together hold QUEUE_DEPTH words; nothing is lost. After reset all
// totals are zero, the hazard window is two, both predictor counters are
// weakly taken and the history is clear; the last-writer table reads zero
// until an entry is written.
// ---------------------------------------------------------------------------
`include "pipeline_hazard_and_branch_profiler_macros.svh"

module pipeline_hazard_and_branch_profiler import phbp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  in_item_t            item,
  output logic                result_valid,
  input  logic                result_ready,
  output out_item_t           result,
  input  logic                cfg_we,
  input  logic [WINDOW_W-1:0] cfg_wdata
);

  localparam int unsigned LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration: largest producer-consumer distance counted as a hazard.
  logic [WINDOW_W-1:0] hazard_window;

  // Front-to-queue and queue-to-back traffic.
  logic               q_push;
  prof_op_t           q_push_op;
  logic               q_pop;
  logic               q_head_valid;
  prof_op_t           q_head_op;
  logic [LEVEL_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      hazard_window <= WINDOW_RESET;
    end else if (cfg_we) begin
      hazard_window <= cfg_wdata;
    end
  end

  // The front end owns the instruction index and the last-writer table, so
  // the index written for an instruction is known on acceptance and the
  // table is always current for the next word.
  phbp_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .hazard_window (hazard_window),
    .q_level       (q_level),
    .push          (q_push),
    .push_op       (q_push_op)
  );

  phbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_push_op),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op),
    .level      (q_level)
  );

  // The back end scores the predictors in order and holds the totals,
  // which stall only against the result channel.
  phbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head_op      (q_head_op),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The front end never pushes into a full queue.
  `PHBP_ASSERT_IMP(a_queue_no_overflow, q_push && !q_pop, q_level < LEVEL_W'(QUEUE_DEPTH))
  // Every accepted word reaches the queue on the next cycle.
  `PHBP_ASSERT_NEXT(a_accept_reaches_queue, item_valid && item_ready, q_push)
  // Scoring a word always presents a result on the next cycle.
  `PHBP_ASSERT_NEXT(a_pop_gives_result, q_pop, result_valid)
  // The back end only takes from a filled queue.
  `PHBP_ASSERT_IMP(a_pop_from_filled, q_pop, q_level != '0)

endmodule

>>> tb/profiler_totals_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Profiler totals checker
// Follows the instruction words that the profiler accepts, keeps its own
// hazard table, counters and predictors, and compares every result word
// with the running totals it expects.
// ---------------------------------------------------------------------------
module profiler_totals_checker import phbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  in_item_t            item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  out_item_t           result,
  input  logic                cfg_we,
  input  logic [WINDOW_W-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  outstanding,
  output int                  words_checked
);

  localparam int HI_IDX = NUM_REGS;
  localparam int LO_IDX = NUM_REGS + 1;

  string field_names [6] = '{"instructions_seen", "hazards_seen", "branches_seen",
                             "static_misses", "bimodal_misses", "two_level_misses"};

  logic [WINDOW_W-1:0]     window;
  logic [CNT_W-1:0]        n_instr, n_hazard, n_branch;
  logic [CNT_W-1:0]        n_static_miss, n_bimodal_miss, n_two_level_miss;
  logic [1:0]              bimodal_ctr;
  logic [HISTORY_BITS-1:0] history;
  logic [1:0]              pattern_ctr [PATTERN_ENTRIES];
  logic [CNT_W-1:0]        writer_index [NUM_REGS + 2];
  out_item_t               totals_due [$];

  function automatic logic written_recently(input logic [REG_W-1:0] r);
    logic [CNT_W-1:0] span;
    span = n_instr - writer_index[r];
    return span <= CNT_W'(window);
  endfunction

  function automatic logic [1:0] saturate(input logic [1:0] c, input logic up);
    if (up) return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
  endfunction

  function automatic logic cond_branch(input logic [5:0] op);
    return op == OP_REGIMM || op == OP_BEQ || op == OP_BNE || op == OP_BLEZ || op == OP_BGTZ;
  endfunction

  // Advances the mirrored state by one retired instruction.
  task automatic retire_instruction(input in_item_t w, output out_item_t totals);
    logic [5:0]              fn;
    logic                    r_form, i_form, hazard, no_write;
    logic [HISTORY_BITS-1:0] h;
    logic [HISTORY_BITS:0]   shifted;
    r_form = (w.instr_class == CLASS_R);
    i_form = (w.instr_class == CLASS_I);
    fn = r_form ? w.func : FN_NONE;
    n_instr = n_instr + 1;

    hazard = 1'b0;
    if (r_form) begin
      hazard = (w.src_reg != 0 && written_recently(w.src_reg)) ||
               (w.second_reg != 0 && written_recently(w.second_reg));
    end else if (i_form) begin
      if (w.opcode == OP_LUI) begin
        hazard = 1'b0;
      end else if ((w.opcode == OP_BEQ || w.opcode == OP_BNE) &&
                   (w.src_reg != 0 || w.second_reg != 0)) begin
        // Equality branches read both operands, register zero included.
        hazard = written_recently(w.src_reg) || written_recently(w.second_reg);
      end else if (w.src_reg != 0) begin
        hazard = written_recently(w.src_reg);
      end
    end
    if (hazard) n_hazard = n_hazard + 1;

    no_write = !(r_form || i_form);
    if (w.opcode == OP_SPECIAL && (fn == FN_JR || fn == FN_SYSCALL || fn == FN_BREAK))
      no_write = 1'b1;
    if (fn == FN_NONE && (cond_branch(w.opcode) || w.opcode == OP_SB || w.opcode == OP_SH ||
                          w.opcode == OP_SW || w.opcode == OP_SWC1))
      no_write = 1'b1;
    if (!no_write) begin
      if (fn == FN_MULT || fn == FN_MULTU || fn == FN_DIV || fn == FN_DIVU) begin
        writer_index[HI_IDX] = n_instr;
        writer_index[LO_IDX] = n_instr;
      end else if (fn == FN_MTHI) begin
        writer_index[HI_IDX] = n_instr;
      end else if (fn == FN_MTLO) begin
        writer_index[LO_IDX] = n_instr;
      end else if (r_form) begin
        writer_index[w.dest_reg] = n_instr;
      end else begin
        writer_index[w.second_reg] = n_instr;
      end
    end

    if (i_form && cond_branch(w.opcode)) begin
      h = history;
      n_branch = n_branch + 1;
      if (w.branch_taken != w.branch_offset[15]) n_static_miss = n_static_miss + 1;
      if (w.branch_taken != bimodal_ctr[1]) n_bimodal_miss = n_bimodal_miss + 1;
      bimodal_ctr = saturate(bimodal_ctr, w.branch_taken);
      if (w.branch_taken != pattern_ctr[h][1]) n_two_level_miss = n_two_level_miss + 1;
      pattern_ctr[h] = saturate(pattern_ctr[h], w.branch_taken);
      shifted = {h, w.branch_taken};
      history = shifted[HISTORY_BITS-1:0];
    end

    totals.instructions_seen = n_instr;
    totals.hazards_seen      = n_hazard;
    totals.branches_seen     = n_branch;
    totals.static_misses     = n_static_miss;
    totals.bimodal_misses    = n_bimodal_miss;
    totals.two_level_misses  = n_two_level_miss;
  endtask

  always @(posedge clk) begin
    out_item_t         due, predicted;
    logic [6*CNT_W-1:0] due_bits, got_bits;
    if (rst) begin
      window           = WINDOW_RESET;
      n_instr          = '0;
      n_hazard         = '0;
      n_branch         = '0;
      n_static_miss    = '0;
      n_bimodal_miss   = '0;
      n_two_level_miss = '0;
      bimodal_ctr      = CTR_WEAK_TAKEN;
      history          = '0;
      for (int i = 0; i < PATTERN_ENTRIES; i++) pattern_ctr[i] = CTR_WEAK_TAKEN;
      for (int i = 0; i < NUM_REGS + 2; i++) writer_index[i] = '0;
      totals_due.delete();
      mismatches    = 0;
      words_checked = 0;
    end else begin
      if (cfg_we) window = cfg_wdata;
      if (result_valid && result_ready) begin
        if (totals_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word arrived with none expected", $realtime);
        end else begin
          due = totals_due.pop_front();
          due_bits = due;
          got_bits = result;
          for (int k = 0; k < 6; k++) begin
            if (got_bits[(5-k)*CNT_W +: CNT_W] !== due_bits[(5-k)*CNT_W +: CNT_W]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("%0t: word %0d %s expected %0d got %0d", $realtime,
                         words_checked + 1, field_names[k],
                         due_bits[(5-k)*CNT_W +: CNT_W], got_bits[(5-k)*CNT_W +: CNT_W]);
            end
          end
          words_checked++;
        end
      end
      if (item_valid && item_ready) begin
        retire_instruction(item, predicted);
        totals_due.push_back(predicted);
      end
    end
    outstanding = totals_due.size();
  end

endmodule

>>> tb/tb_pipeline_hazard_and_branch_profiler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipeline hazard and branch profiler testbench
// Feeds directed and random instruction words, including small loops closed
// by backward branches, under several hazard-window settings, with random
// gaps on the sender and stalls on the receiver. A separate checker module
// predicts and compares the totals; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_pipeline_hazard_and_branch_profiler;
  import phbp_pkg::*;

  // Generous bound: the slowest legal run stays far below this.
  localparam int CYCLE_LIMIT  = 400000;
  // Wait after the last result word before the block is treated as settled.
  localparam int DRAIN_CYCLES = 8;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  in_item_t            item;
  logic                result_valid;
  logic                result_ready;
  out_item_t           result;
  logic                cfg_we;
  logic [WINDOW_W-1:0] cfg_wdata;

  int   mismatches, outstanding, words_checked;
  int   sent = 0;
  int   windows_used = 1;  // the reset value counts as the first setting
  int   cycles = 0;
  logic calm = 1'b0;       // when set, neither side idles

  pipeline_hazard_and_branch_profiler dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  profiler_totals_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result word ends up here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pipeline_hazard_and_branch_profiler test failed");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // Registers come mostly from a small pool, so that producer and consumer
  // distances fall around every window setting; the rest span all 32.
  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(0, 99) < 70) return REG_W'($urandom_range(0, 7));
    return REG_W'($urandom_range(0, 31));
  endfunction

  function automatic in_item_t encode_word(input instr_class_t c, input logic [5:0] op,
                                           input logic [5:0] fn, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [4:0] rd,
                                           input logic tk, input logic signed [15:0] off);
    in_item_t w;
    w.instr_class   = c;
    w.opcode        = op;
    w.func          = fn;
    w.src_reg       = rs;
    w.second_reg    = rt;
    w.dest_reg      = rd;
    w.branch_taken  = tk;
    w.branch_offset = off;
    return w;
  endfunction

  // A random instruction word. Register-type words favour the function codes
  // that the profiler treats specially; immediate-type words favour branches,
  // stores and LUI. Branches can be left out for loop bodies.
  function automatic in_item_t random_word(input logic allow_branch);
    in_item_t w;
    int       pick;
    w.src_reg       = pick_reg();
    w.second_reg    = pick_reg();
    w.dest_reg      = pick_reg();
    w.branch_taken  = 1'($urandom_range(0, 1));
    w.branch_offset = 16'($urandom_range(0, 65535));
    w.opcode        = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < 85) w.func = FN_NONE;
    else w.func = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.instr_class = CLASS_R;
      if ($urandom_range(0, 4) != 0) w.opcode = OP_SPECIAL;
      if ($urandom_range(0, 99) < 40) begin
        w.func = 6'($urandom_range(0, 63));
      end else begin
        case ($urandom_range(0, 9))
          0: w.func = FN_NONE;
          1: w.func = FN_JR;
          2: w.func = FN_SYSCALL;
          3: w.func = FN_BREAK;
          4: w.func = FN_MTHI;
          5: w.func = FN_MTLO;
          6: w.func = FN_MULT;
          7: w.func = FN_MULTU;
          8: w.func = FN_DIV;
          default: w.func = FN_DIVU;
        endcase
      end
    end else if (pick < 88) begin
      w.instr_class = CLASS_I;
      case ($urandom_range(allow_branch ? 0 : 5, 11))
        0: w.opcode = OP_BEQ;
        1: w.opcode = OP_BNE;
        2: w.opcode = OP_BLEZ;
        3: w.opcode = OP_BGTZ;
        4: w.opcode = OP_REGIMM;
        5: w.opcode = OP_LUI;
        6: w.opcode = OP_SW;
        7: w.opcode = OP_SB;
        8: w.opcode = OP_SH;
        9: w.opcode = OP_SWC1;
        10: w.opcode = OP_SPECIAL;
        default: ;  // keep the random opcode
      endcase
    end else if (pick < 95) begin
      w.instr_class = CLASS_J;
    end else begin
      w.instr_class = CLASS_X;
    end
    return w;
  endfunction

  // Presents one word and holds it until it is accepted, then leaves a
  // random gap. Called and returns at a falling edge. With no gap the valid
  // simply stays high and the next call replaces the payload.
  task automatic send_word(input in_item_t w);
    int gap;
    item       = w;
    item_valid = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
    @(negedge clk);
    gap = calm ? 0 : gap_length();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // The window is only written once every result word has been taken and
  // the pipe has had time to settle.
  task automatic write_window(input logic [WINDOW_W-1:0] v);
    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    windows_used++;
  endtask

  // Mostly small loops: a fixed body closed by a branch that is taken on
  // every trip but the last, repeated a few times so that the counters and
  // the history have a pattern to learn. The rest is loose random words.
  task automatic random_phase(input int quota);
    int                 start, body_len, trips, reps;
    logic [5:0]         close_op;
    logic [4:0]         close_rs, close_rt;
    logic signed [15:0] jump_back;
    in_item_t           body [6];
    start = sent;
    while (sent - start < quota) begin
      if ($urandom_range(0, 99) < 65) begin
        body_len = $urandom_range(1, 5);
        trips    = $urandom_range(1, 6);
        reps     = $urandom_range(1, 3);
        for (int i = 0; i < body_len; i++) body[i] = random_word(1'b0);
        case ($urandom_range(0, 4))
          0: close_op = OP_BNE;
          1: close_op = OP_BEQ;
          2: close_op = OP_BGTZ;
          3: close_op = OP_BLEZ;
          default: close_op = OP_REGIMM;
        endcase
        close_rs  = pick_reg();
        close_rt  = pick_reg();
        jump_back = 16'(body_len + 1);
        jump_back = -jump_back;
        // Occasionally a forward jump, which the static rule gets wrong.
        if ($urandom_range(0, 9) == 0) jump_back = 16'($urandom_range(1, 32767));
        repeat (reps) begin
          for (int t = 0; t < trips; t++) begin
            for (int i = 0; i < body_len; i++) send_word(body[i]);
            send_word(encode_word(CLASS_I, close_op, FN_NONE, close_rs, close_rt, '0,
                                  t != trips - 1, jump_back));
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_word(random_word(1'b1));
      end
    end
  endtask

  // Receiver: random stalls of the same shape as the sender's gaps, none
  // while the calm flag is up.
  initial begin
    int hold;
    hold = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        hold = 0;
        result_ready = 1'b1;
      end else if (hold > 0) begin
        result_ready = 1'b0;
        hold--;
      end else begin
        result_ready = 1'b1;
        hold = gap_length();
      end
    end
  end

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset window of two. The first reads hit
    // registers that have never been written, whose table entries are zero,
    // so they count as hazards.
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_NONE, 5'd1, 5'd2, 5'd3, 1'b0, '0));
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_MULT, 5'd3, 5'd4, 5'd0, 1'b0, '0));
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_MTHI, 5'd5, 5'd0, 5'd7, 1'b0, '0));
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_MTLO, 5'd6, 5'd0, 5'd8, 1'b0, '0));
    // Jump register, syscall and break write nothing.
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_JR, 5'd31, 5'd0, 5'd9, 1'b0, '0));
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_SYSCALL, 5'd0, 5'd0, 5'd9, 1'b0, '0));
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_BREAK, 5'd0, 5'd0, 5'd9, 1'b0, '0));
    // A register-type word with a branch opcode and a zero function field
    // is not written back either.
    send_word(encode_word(CLASS_R, OP_BEQ, FN_NONE, 5'd0, 5'd0, 5'd9, 1'b0, '0));
    // LUI reads nothing and writes rt.
    send_word(encode_word(CLASS_I, OP_LUI, FN_NONE, 5'd3, 5'd10, 5'd0, 1'b0, '0));
    // Equality branch on register zero twice reads nothing; most negative offset.
    send_word(encode_word(CLASS_I, OP_BEQ, FN_NONE, 5'd0, 5'd0, 5'd0, 1'b1, 16'sh8000));
    // Register zero as a destination is tracked, and then read by a branch.
    send_word(encode_word(CLASS_R, OP_SPECIAL, FN_NONE, 5'd0, 5'd0, 5'd0, 1'b0, '0));
    send_word(encode_word(CLASS_I, OP_BNE, FN_NONE, 5'd0, 5'd31, 5'd0, 1'b0, 16'sh7FFF));
    send_word(encode_word(CLASS_I, OP_BLEZ, FN_NONE, 5'd10, 5'd0, 5'd0, 1'b1, 16'sh0004));
    send_word(encode_word(CLASS_I, OP_BGTZ, FN_NONE, 5'd31, 5'd31, 5'd31, 1'b0, -16'sd4));
    send_word(encode_word(CLASS_I, OP_REGIMM, FN_NONE, 5'd31, 5'd17, 5'd0, 1'b1, -16'sd1));
    // Stores read rs and write nothing.
    send_word(encode_word(CLASS_I, OP_SW, FN_NONE, 5'd2, 5'd31, 5'd0, 1'b0, '0));
    send_word(encode_word(CLASS_I, OP_SB, FN_NONE, 5'd17, 5'd12, 5'd0, 1'b0, '0));
    send_word(encode_word(CLASS_I, OP_SH, FN_NONE, 5'd12, 5'd13, 5'd0, 1'b0, '0));
    send_word(encode_word(CLASS_I, OP_SWC1, FN_NONE, 5'd13, 5'd14, 5'd0, 1'b0, '0));
    // Outside register type the function field is ignored.
    send_word(encode_word(CLASS_I, OP_SPECIAL, FN_JR, 5'd12, 5'd13, 5'd0, 1'b0, '0));
    send_word(encode_word(CLASS_J, OP_BEQ, FN_MULT, 5'd13, 5'd10, 5'd5, 1'b1, -16'sd8));
    // The unused class behaves as a jump; every field at its all-ones value.
    send_word(encode_word(CLASS_X, '1, '1, '1, '1, '1, 1'b1, -16'sd1));
    send_word(encode_word(CLASS_R, '1, FN_DIVU, 5'd13, 5'd10, 5'd31, 1'b0, '0));

    // Random phases, each under its own window, the extremes among them.
    write_window(4'd0);
    random_phase(70);
    write_window(4'd15);
    random_phase(75);
    write_window(4'd1);
    random_phase(70);
    // One phase with neither side idling.
    calm = 1'b1;
    write_window(WINDOW_W'($urandom_range(3, 14)));
    random_phase(70);
    calm = 1'b0;
    write_window(4'd4);
    random_phase(75);
    write_window(4'd15);
    random_phase(70);

    // Wait for the last result word, then give the pipe time to show any
    // word that was not asked for.
    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Profiled %0d instruction words, loops and loose words, under %0d window settings",
             sent, windows_used);
    $display("from 0 to 15; %0d result words compared field by field.", words_checked);
    if (mismatches == 0) begin
      $display("pipeline_hazard_and_branch_profiler test passed");
    end else begin
      $display("pipeline_hazard_and_branch_profiler test failed");
    end
    $finish;
  end

endmodule
